[hw/rtl/tds_pkg.sv]
// tds_pkg: token kinds, scanner states, character classes, keyword table
// and the structs shared by the token scanner modules
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tds_pkg;

  localparam int KIND_W = 4;
  localparam int LEN_W  = 6;
  localparam int ST_W   = 4;
  localparam int KW_N   = 4;
  localparam int KW_MAX = 8;

  // token kinds; the keywords take their table index as kind
  localparam logic [KIND_W-1:0] TK_INICIO   = 4'd0;
  localparam logic [KIND_W-1:0] TK_FIN      = 4'd1;
  localparam logic [KIND_W-1:0] TK_LEER     = 4'd2;
  localparam logic [KIND_W-1:0] TK_ESCRIBIR = 4'd3;
  localparam logic [KIND_W-1:0] TK_ID       = 4'd4;
  localparam logic [KIND_W-1:0] TK_CONST    = 4'd5;
  localparam logic [KIND_W-1:0] TK_LPAR     = 4'd6;
  localparam logic [KIND_W-1:0] TK_RPAR     = 4'd7;
  localparam logic [KIND_W-1:0] TK_SEMI     = 4'd8;
  localparam logic [KIND_W-1:0] TK_COMMA    = 4'd9;
  localparam logic [KIND_W-1:0] TK_ASSIGN   = 4'd10;
  localparam logic [KIND_W-1:0] TK_PLUS     = 4'd11;
  localparam logic [KIND_W-1:0] TK_MINUS    = 4'd12;
  localparam logic [KIND_W-1:0] TK_END      = 4'd13;
  localparam logic [KIND_W-1:0] TK_ERROR    = 4'd14;

  // scanner states
  localparam logic [ST_W-1:0] ST_START = 4'd0;
  localparam logic [ST_W-1:0] ST_NAME  = 4'd1;
  localparam logic [ST_W-1:0] ST_NUM   = 4'd3;
  localparam logic [ST_W-1:0] ST_COLON = 4'd11;

  // character classes
  localparam logic [3:0] CL_ALPHA = 4'd0;
  localparam logic [3:0] CL_DIGIT = 4'd1;
  localparam logic [3:0] CL_PLUS  = 4'd2;
  localparam logic [3:0] CL_MINUS = 4'd3;
  localparam logic [3:0] CL_LPAR  = 4'd4;
  localparam logic [3:0] CL_RPAR  = 4'd5;
  localparam logic [3:0] CL_COMMA = 4'd6;
  localparam logic [3:0] CL_SEMI  = 4'd7;
  localparam logic [3:0] CL_COLON = 4'd8;
  localparam logic [3:0] CL_EQ    = 4'd9;
  localparam logic [3:0] CL_END   = 4'd10;
  localparam logic [3:0] CL_SPACE = 4'd11;
  localparam logic [3:0] CL_OTHER = 4'd12;

  localparam logic [7:0] KW_TEXT [KW_N][KW_MAX] = '{
    '{"i", "n", "i", "c", "i", "o", 8'h00, 8'h00},
    '{"f", "i", "n", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"l", "e", "e", "r", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"e", "s", "c", "r", "i", "b", "i", "r"}
  };
  localparam logic [3:0] KW_LEN [KW_N] = '{4'd6, 4'd3, 4'd4, 4'd8};

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [LEN_W-1:0]  len;
    logic              last;
  } tds_tok_t;

  typedef struct packed {
    logic [ST_W-1:0]  state;
    logic [LEN_W-1:0] count;
    logic [KW_N-1:0]  alive;
  } tds_scan_t;

  typedef struct packed {
    logic [1:0] num;
    tds_tok_t   tok0;
    tds_tok_t   tok1;
  } tds_step_t;

  function automatic logic [3:0] classify(input logic [7:0] c);
    logic [3:0] cls;
    case (c) inside
      [8'h41:8'h5A], [8'h61:8'h7A]:               cls = CL_ALPHA;
      [8'h30:8'h39]:                               cls = CL_DIGIT;
      8'h2B:                                       cls = CL_PLUS;
      8'h2D:                                       cls = CL_MINUS;
      8'h28:                                       cls = CL_LPAR;
      8'h29:                                       cls = CL_RPAR;
      8'h2C:                                       cls = CL_COMMA;
      8'h3B:                                       cls = CL_SEMI;
      8'h3A:                                       cls = CL_COLON;
      8'h3D:                                       cls = CL_EQ;
      8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D:   cls = CL_SPACE;
      default:                                     cls = CL_OTHER;
    endcase
    return cls;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/tds_if.sv]
// tds_in_if, tds_out_if: valid/ready channels of the token scanner
// depends on tds_pkg
`timescale 1ns / 1ps
`default_nettype none

interface tds_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_input;

  modport source (output valid, output char_code, output end_of_input, input ready);
  modport sink   (input valid, input char_code, input end_of_input, output ready);
endinterface

interface tds_out_if import tds_pkg::*;;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] token_kind;
  logic [LEN_W-1:0]  lexeme_length;
  logic              last_of_run;

  modport source (output valid, output token_kind, output lexeme_length,
                  output last_of_run, input ready);
  modport sink   (input valid, input token_kind, input lexeme_length,
                  input last_of_run, output ready);
endinterface

`default_nettype wire

[hw/rtl/tds_step.sv]
// tds_step: one automaton step, next scanner state and up to two tokens
// depends on tds_pkg
`timescale 1ns / 1ps
`default_nettype none

module tds_step import tds_pkg::*; #(
  parameter int MAX_LEXEME = 32
) (
  input  tds_scan_t  scan,
  input  logic [7:0] char_code,
  input  logic       end_of_input,
  output tds_scan_t  scan_nxt,
  output tds_step_t  step
);

  localparam logic [LEN_W-1:0] SAT = LEN_W'(MAX_LEXEME);

  logic [3:0]        cls;
  tds_scan_t         fs_scan;
  logic              fs_emit;
  tds_tok_t          fs_tok;
  logic [KW_N-1:0]   ext_alive;
  logic [LEN_W-1:0]  bumped;
  logic [KIND_W-1:0] name_kind;
  logic [1:0]        num;
  tds_tok_t          tok0;
  tds_tok_t          tok1;

  assign cls    = end_of_input ? CL_END : classify(char_code);
  assign bumped = (scan.count < SAT) ? scan.count + LEN_W'(1) : SAT;

  // keyword prefix tracking for one more name character
  always_comb begin
    for (int k = 0; k < KW_N; k++) begin
      ext_alive[k] = scan.alive[k] && (scan.count < {2'b00, KW_LEN[k]}) &&
                     (KW_TEXT[k][scan.count[2:0]] == char_code);
    end
  end

  // lowest keyword index wins
  always_comb begin
    name_kind = TK_ID;
    for (int k = KW_N - 1; k >= 0; k--) begin
      if (scan.alive[k] && (scan.count == {2'b00, KW_LEN[k]})) begin
        name_kind = KIND_W'(k);
      end
    end
  end

  // what the start state does with this character
  always_comb begin
    fs_scan.state = ST_START;
    fs_scan.count = '0;
    fs_scan.alive = '1;
    fs_emit       = 1'b1;
    fs_tok.kind   = TK_ERROR;
    fs_tok.len    = LEN_W'(1);
    fs_tok.last   = 1'b0;
    case (cls)
      CL_ALPHA: begin
        fs_emit       = 1'b0;
        fs_scan.state = ST_NAME;
        fs_scan.count = LEN_W'(1);
        for (int k = 0; k < KW_N; k++) begin
          fs_scan.alive[k] = (KW_TEXT[k][0] == char_code);
        end
      end
      CL_DIGIT: begin
        fs_emit       = 1'b0;
        fs_scan.state = ST_NUM;
        fs_scan.count = LEN_W'(1);
      end
      CL_COLON: begin
        fs_emit       = 1'b0;
        fs_scan.state = ST_COLON;
        fs_scan.count = LEN_W'(1);
      end
      CL_PLUS:  fs_tok.kind = TK_PLUS;
      CL_MINUS: fs_tok.kind = TK_MINUS;
      CL_LPAR:  fs_tok.kind = TK_LPAR;
      CL_RPAR:  fs_tok.kind = TK_RPAR;
      CL_COMMA: fs_tok.kind = TK_COMMA;
      CL_SEMI:  fs_tok.kind = TK_SEMI;
      CL_END: begin
        fs_tok.kind = TK_END;
        fs_tok.len  = '0;
      end
      CL_SPACE: fs_emit = 1'b0;
      default:  fs_tok.kind = TK_ERROR;
    endcase
  end

  always_comb begin
    scan_nxt   = fs_scan;
    num        = {1'b0, fs_emit};
    tok0       = fs_tok;
    tok1       = fs_tok;
    tok0.last  = 1'b0;
    tok1.last  = 1'b0;
    unique case (scan.state)
      ST_NAME: begin
        if (cls == CL_ALPHA || cls == CL_DIGIT) begin
          scan_nxt = '{state: ST_NAME, count: bumped, alive: ext_alive};
          num      = 2'd0;
        end else begin
          tok0.kind = name_kind;
          tok0.len  = scan.count;
          num       = fs_emit ? 2'd2 : 2'd1;
        end
      end
      ST_NUM: begin
        if (cls == CL_DIGIT) begin
          scan_nxt = '{state: ST_NUM, count: bumped, alive: scan.alive};
          num      = 2'd0;
        end else begin
          tok0.kind = TK_CONST;
          tok0.len  = scan.count;
          num       = fs_emit ? 2'd2 : 2'd1;
        end
      end
      ST_COLON: begin
        scan_nxt = '{state: ST_START, count: '0, alive: '1};
        num      = 2'd1;
        if (cls == CL_EQ) begin
          tok0.kind = TK_ASSIGN;
          tok0.len  = LEN_W'(2);
        end else if (cls == CL_END) begin
          tok0.kind = TK_ERROR;
          tok0.len  = LEN_W'(1);
          tok1.kind = TK_END;
          tok1.len  = '0;
          num       = 2'd2;
        end else begin
          tok0.kind = TK_ERROR;
          tok0.len  = (cls == CL_SPACE) ? LEN_W'(1) : LEN_W'(2);
        end
      end
      default: begin
      end
    endcase
    tok0.last = (num == 2'd1);
    tok1.last = 1'b1;
  end

  assign step.num  = num;
  assign step.tok0 = tok0;
  assign step.tok1 = tok1;

endmodule

`default_nettype wire

[hw/rtl/tds_outq.sv]
// tds_outq: four-entry shifting token queue, takes up to two tokens a cycle
// and hands out one; depends on tds_pkg
`timescale 1ns / 1ps
`default_nettype none

module tds_outq import tds_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  tds_step_t step,
  input  logic      pop,
  output tds_tok_t  head,
  output logic      head_v,
  output logic      room
);

  localparam int DEPTH = 4;
  localparam int CNT_W = $clog2(DEPTH + 1);

  tds_tok_t         slot_r   [DEPTH];
  tds_tok_t         slot_nxt [DEPTH];
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic [CNT_W-1:0] base;
  logic [1:0]       add;

  assign head   = slot_r[0];
  assign head_v = (cnt_r != '0);
  // room for a full pair of tokens
  assign room   = (cnt_r <= CNT_W'(DEPTH - 2));
  assign add    = push ? step.num : 2'd0;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      slot_nxt[i] = slot_r[i];
    end
    base = cnt_r;
    if (pop) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        slot_nxt[i] = slot_r[i + 1];
      end
      base = cnt_r - CNT_W'(1);
    end
    for (int i = 0; i < DEPTH; i++) begin
      if (add != 2'd0 && base == CNT_W'(i)) begin
        slot_nxt[i] = step.tok0;
      end
      if (add == 2'd2 && base + CNT_W'(1) == CNT_W'(i)) begin
        slot_nxt[i] = step.tok1;
      end
    end
    cnt_nxt = base + CNT_W'(add);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      slot_r[i] <= slot_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/table_driven_token_scanner.sv]
// table_driven_token_scanner: character-class lexer top level
// depends on tds_pkg, tds_if, tds_step, tds_outq
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  handshake     payload
// in_chan   in   valid/ready   char_code[7:0], end_of_input
// out_chan  out   valid/ready   token_kind[3:0], lexeme_length[5:0], last_of_run
//
// one byte a cycle while the queue has room: the automaton step is one
// combinational pass from the scanner state register into a four-entry token queue
// an item yields zero, one or two tokens; the queue drains one per cycle while
// out_chan.ready is high, so output bandwidth sets the sustained rate once tokens pile up
// in_chan.ready is high while the queue has room for two tokens
// synchronous active-low reset: start state, empty queue

module table_driven_token_scanner import tds_pkg::*; #(
  parameter int MAX_LEXEME = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  tds_in_if.sink   in_chan,
  tds_out_if.source out_chan
);

  tds_scan_t scan_r;
  tds_scan_t scan_nxt;
  tds_step_t step;
  tds_tok_t  head;
  logic      head_v;
  logic      room;
  logic      in_xfer;
  logic      out_xfer;

  assign in_chan.ready = room;
  assign in_xfer       = in_chan.valid && room;
  assign out_xfer      = head_v && out_chan.ready;

  // automaton step: class lookup, keyword prefix compare, token build
  tds_step #(
    .MAX_LEXEME (MAX_LEXEME)
  ) u_step (
    .scan         (scan_r),
    .char_code    (in_chan.char_code),
    .end_of_input (in_chan.end_of_input),
    .scan_nxt     (scan_nxt),
    .step         (step)
  );

  // scanner state advances only on an input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r.state <= ST_START;
      scan_r.count <= '0;
      scan_r.alive <= '1;
    end else if (in_xfer) begin
      scan_r <= scan_nxt;
    end
  end

  // result queue parts the two sides
  tds_outq u_outq (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (in_xfer),
    .step   (step),
    .pop    (out_xfer),
    .head   (head),
    .head_v (head_v),
    .room   (room)
  );

  assign out_chan.valid         = head_v;
  assign out_chan.token_kind    = head.kind;
  assign out_chan.lexeme_length = head.len;
  assign out_chan.last_of_run   = head.last;

  // input only stalls behind pending results
  a_stall_has_results: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> out_chan.valid)
    else $error("input stalled with no result pending");

  // end of text always returns the scanner to a clean start
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_chan.end_of_input |=>
      (scan_r.state == ST_START) && (scan_r.count == '0) && (scan_r.alive == '1))
    else $error("scanner not cleared after end of text");

  // an open name or constant holds at least one character
  a_open_lexeme: assert property (@(posedge clk) disable iff (!rst_n)
    (scan_r.state == ST_NAME || scan_r.state == ST_NUM) |-> scan_r.count != '0)
    else $error("open lexeme with zero length");

  // a token pair marks only the second as last of run
  a_pair_last: assert property (@(posedge clk) disable iff (!rst_n)
    step.num == 2'd2 |-> !step.tok0.last && step.tok1.last)
    else $error("bad last_of_run on token pair");

endmodule

`default_nettype wire

[dv/tds_scan_checker.sv]
// tds_scan_checker: watches both scanner channels, predicts the token stream
// from the accepted bytes and compares every token transfer in order
// depends on tds_pkg and the tds_in_if / tds_out_if channels
`timescale 1ns / 1ps

module tds_scan_checker import tds_pkg::*; #(
  parameter int MAX_LEXEME = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  tds_in_if           in_chan,
  tds_out_if          out_chan,
  output int          fault_count,
  output int          tokens_due,
  output int          items_taken,
  output int          tokens_checked,
  output logic [15:0] kinds_hit
);

  localparam logic [KIND_W-1:0] KW_KIND [KW_N] = '{TK_INICIO, TK_FIN, TK_LEER, TK_ESCRIBIR};

  string kw_word [KW_N] = '{"inicio", "fin", "leer", "escribir"};

  // scanner state as the predictor sees it
  logic [ST_W-1:0]  scan_st;
  logic [LEN_W-1:0] lex_cnt;
  logic [KW_N-1:0]  kw_alive;

  tds_tok_t    token_q [$];
  tds_tok_t    step_toks [$];
  int          faults;
  int          n_items;
  int          n_tokens;
  logic [15:0] seen;

  function automatic logic [3:0] byte_class(input logic [7:0] c);
    if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")) return CL_ALPHA;
    if (c >= "0" && c <= "9") return CL_DIGIT;
    case (c)
      "+":                                       return CL_PLUS;
      "-":                                       return CL_MINUS;
      "(":                                       return CL_LPAR;
      ")":                                       return CL_RPAR;
      ",":                                       return CL_COMMA;
      ";":                                       return CL_SEMI;
      ":":                                       return CL_COLON;
      "=":                                       return CL_EQ;
      8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D: return CL_SPACE;
      default:                                   return CL_OTHER;
    endcase
  endfunction

  function automatic void add_token(input logic [KIND_W-1:0] kind,
                                    input logic [LEN_W-1:0] len);
    tds_tok_t t;
    t.kind = kind;
    t.len  = len;
    t.last = 1'b0;
    step_toks.push_back(t);
  endfunction

  function automatic void count_up();
    if (int'(lex_cnt) < MAX_LEXEME) lex_cnt = lex_cnt + 1'b1;
    else lex_cnt = LEN_W'(MAX_LEXEME);
  endfunction

  // drop every keyword that the name no longer spells
  function automatic void grow_name(input logic [7:0] c);
    for (int k = 0; k < KW_N; k++) begin
      if (kw_alive[k] && (int'(lex_cnt) >= kw_word[k].len() || kw_word[k][lex_cnt] != c))
        kw_alive[k] = 1'b0;
    end
    count_up();
  endfunction

  function automatic logic [KIND_W-1:0] name_kind();
    for (int k = 0; k < KW_N; k++) begin
      if (kw_alive[k] && int'(lex_cnt) == kw_word[k].len()) return KW_KIND[k];
    end
    return TK_ID;
  endfunction

  function automatic void restart();
    scan_st  = ST_START;
    lex_cnt  = '0;
    kw_alive = '1;
  endfunction

  function automatic void enter(input logic [3:0] cls, input logic [7:0] c);
    restart();
    case (cls)
      CL_ALPHA: begin
        scan_st = ST_NAME;
        grow_name(c);
      end
      CL_DIGIT: begin
        scan_st = ST_NUM;
        lex_cnt = 6'd1;
      end
      CL_COLON: begin
        scan_st = ST_COLON;
        lex_cnt = 6'd1;
      end
      CL_PLUS:  add_token(TK_PLUS, 6'd1);
      CL_MINUS: add_token(TK_MINUS, 6'd1);
      CL_LPAR:  add_token(TK_LPAR, 6'd1);
      CL_RPAR:  add_token(TK_RPAR, 6'd1);
      CL_COMMA: add_token(TK_COMMA, 6'd1);
      CL_SEMI:  add_token(TK_SEMI, 6'd1);
      CL_END:   add_token(TK_END, 6'd0);
      CL_SPACE: ;
      default:  add_token(TK_ERROR, 6'd1);
    endcase
  endfunction

  function automatic void predict_tokens(input logic [7:0] c, input logic eot);
    logic [3:0] cls;
    cls = eot ? CL_END : byte_class(c);
    step_toks.delete();
    case (scan_st)
      ST_NAME: begin
        if (cls == CL_ALPHA || cls == CL_DIGIT) begin
          grow_name(c);
        end else begin
          add_token(name_kind(), lex_cnt);
          enter(cls, c);
        end
      end
      ST_NUM: begin
        if (cls == CL_DIGIT) begin
          count_up();
        end else begin
          add_token(TK_CONST, lex_cnt);
          enter(cls, c);
        end
      end
      ST_COLON: begin
        if (cls == CL_EQ) begin
          add_token(TK_ASSIGN, 6'd2);
        end else if (cls == CL_END) begin
          add_token(TK_ERROR, 6'd1);
          add_token(TK_END, 6'd0);
        end else begin
          add_token(TK_ERROR, (cls == CL_SPACE) ? 6'd1 : 6'd2);
        end
        restart();
      end
      default: enter(cls, c);
    endcase
    if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1'b1;
    foreach (step_toks[i]) token_q.push_back(step_toks[i]);
  endfunction

  always @(posedge clk) begin
    tds_tok_t want;
    tds_tok_t got;
    if (!rst_n) begin
      restart();
      token_q.delete();
      faults   = 0;
      n_items  = 0;
      n_tokens = 0;
      seen     = '0;
    end else begin
      // a token leaving now cannot stem from a byte taken at this same edge
      if (out_chan.valid && out_chan.ready) begin
        got.kind = out_chan.token_kind;
        got.len  = out_chan.lexeme_length;
        got.last = out_chan.last_of_run;
        n_tokens++;
        if (int'(got.kind) < 15) seen[got.kind] = 1'b1;
        if (token_q.size() == 0) begin
          faults++;
          $display("%0t: unexpected token, got kind %0d len %0d last %0b",
                   $time, got.kind, got.len, got.last);
        end else begin
          want = token_q.pop_front();
          if (got.kind !== want.kind || got.len !== want.len || got.last !== want.last) begin
            faults++;
            $display("%0t: token mismatch, expected kind %0d len %0d last %0b, got %0d %0d %0b",
                     $time, want.kind, want.len, want.last, got.kind, got.len, got.last);
          end
        end
      end
      if (in_chan.valid && in_chan.ready) begin
        n_items++;
        predict_tokens(in_chan.char_code, in_chan.end_of_input);
      end
    end
    fault_count    <= faults;
    tokens_due     <= token_q.size();
    items_taken    <= n_items;
    tokens_checked <= n_tokens;
    kinds_hit      <= seen;
  end

endmodule

[dv/tb_top.sv]
// tb_top: drives source text into the token scanner and gives the verdict
// depends on tds_pkg, tds_if, table_driven_token_scanner and tds_scan_checker
`timescale 1ns / 1ps

module tb_top;
  import tds_pkg::*;

  localparam int LEX_CAP      = 32;
  localparam int RANDOM_ITEMS = 1150;
  localparam int PAUSE_AT     = 600;   // sender drains the scanner once here
  localparam int IDLE_LIMIT   = 4000;  // cycles without any transfer
  localparam int DRAIN_WAIT   = 16;

  localparam logic [7:0] BLANKS [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};

  logic        clk;
  logic        rst_n;
  bit          calm;        // phase with no idling on either side
  int          sent;
  int          fault_count;
  int          tokens_due;
  int          items_taken;
  int          tokens_checked;
  logic [15:0] kinds_hit;

  string kw_list [4] = '{"inicio", "fin", "leer", "escribir"};
  string punct       = "+-(),;";

  tds_in_if  in_chan ();
  tds_out_if out_chan ();

  table_driven_token_scanner #(.MAX_LEXEME(LEX_CAP)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  tds_scan_checker #(.MAX_LEXEME(LEX_CAP)) chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_chan        (in_chan),
    .out_chan       (out_chan),
    .fault_count    (fault_count),
    .tokens_due     (tokens_due),
    .items_taken    (items_taken),
    .tokens_checked (tokens_checked),
    .kinds_hit      (kinds_hit)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] rand_letter();
    int r;
    r = $urandom_range(0, 51);
    return (r < 26) ? 8'("A" + r) : 8'("a" + r - 26);
  endfunction

  function automatic logic [7:0] rand_alnum();
    int r;
    r = $urandom_range(0, 61);
    if (r < 10) return 8'("0" + r);
    return rand_letter();
  endfunction

  // one byte transfer, then a random gap with valid low
  task automatic put(input logic [7:0] c, input logic eot);
    int gap;
    in_chan.valid        <= 1'b1;
    in_chan.char_code    <= c;
    in_chan.end_of_input <= eot;
    do @(posedge clk); while (!in_chan.ready);
    sent++;
    if (sent % 150 == 0) calm = ($urandom_range(0, 3) == 0);
    gap = pick_gap();
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put(s[i], 1'b0);
  endtask

  // result side: ready bursts broken by stalls of the same shape as the sender gaps
  initial begin
    int hold;
    out_chan.ready <= 1'b0;
    @(posedge clk);
    forever begin
      hold = pick_gap();
      if (hold > 0) begin
        out_chan.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  // watchdog: any transfer on either channel counts as progress
  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) idle = 0;
      else idle++;
    end
    $display("%0t: watchdog expired, %0d tokens still due", $time, tokens_due);
    $display("tb_top NOT OK");
    $finish;
  end

  initial begin
    int          piece;
    int          n;
    int          k;
    int          r;
    int          stop_at;
    bit          drained;
    logic [7:0]  c;
    string       w;

    in_chan.valid        <= 1'b0;
    in_chan.char_code    <= 8'h00;
    in_chan.end_of_input <= 1'b0;
    rst_n                <= 1'b0;
    sent    = 0;
    drained = 1'b0;
    calm    = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: keyword closed by a paren (two tokens from one byte), keyword
    // closed by a comma, constant, every operator, colon followed by '=',
    // by a letter and by a blank, a lone '=', the byte extremes, a colon and
    // a name cut off by end of text, and end of text from the start state
    put_text("inicio(fin,5;-:=:x: =");
    put(8'h00, 1'b0);
    put(8'hFF, 1'b0);
    put(8'h80, 1'b0);
    put_text("+)");
    put(":", 1'b0);
    put(8'hC3, 1'b1);
    put("q", 1'b0);
    put(8'h5A, 1'b1);
    put(8'h00, 1'b1);

    stop_at = sent + RANDOM_ITEMS;
    while (sent < stop_at) begin
      // once, let the scanner drain completely before going on
      if (!drained && sent >= PAUSE_AT) begin
        drained = 1'b1;
        in_chan.valid <= 1'b0;
        do @(posedge clk); while (tokens_due != 0);
      end

      piece = $urandom_range(0, 99);
      n = ($urandom_range(0, 99) < 4) ? $urandom_range(30, 40) : $urandom_range(1, 8);
      if (piece < 20) begin
        // keyword, prefix of one, keyword with a tail, or one with a case flip
        k = $urandom_range(0, 3);
        w = kw_list[k];
        r = $urandom_range(0, 5);
        if (r == 3) w = w.substr(0, $urandom_range(0, w.len() - 2));
        for (int i = 0; i < w.len(); i++) begin
          c = w[i];
          if (r == 5 && $urandom_range(0, 2) == 0) c = c ^ 8'h20;
          put(c, 1'b0);
        end
        if (r == 4) repeat ($urandom_range(1, 3)) put(rand_alnum(), 1'b0);
      end else if (piece < 40) begin
        put(rand_letter(), 1'b0);
        repeat (n - 1) put(rand_alnum(), 1'b0);
      end else if (piece < 55) begin
        repeat (n) put(8'("0" + $urandom_range(0, 9)), 1'b0);
      end else if (piece < 70) begin
        if ($urandom_range(0, 6) == 0) put_text(":=");
        else put(punct[$urandom_range(0, 5)], 1'b0);
      end else if (piece < 73) begin
        put(8'($urandom_range(0, 255)), 1'b1);
      end else if (piece < 88) begin
        // noise byte anywhere in the code space
        put(8'($urandom_range(0, 255)), 1'b0);
      end else if (piece < 95) begin
        // broken assignment: colon and whatever follows
        put(":", 1'b0);
        if ($urandom_range(0, 5) == 0) put(8'($urandom_range(0, 255)), 1'b1);
        else put(8'($urandom_range(0, 255)), 1'b0);
      end else begin
        put("=", 1'b0);
      end

      // separator after a word: blanks, nothing, or an operator or punctuation byte
      if (piece < 55) begin
        r = $urandom_range(0, 99);
        if (r < 45) repeat ($urandom_range(1, 2)) put(BLANKS[$urandom_range(0, 5)], 1'b0);
        else if (r >= 75) put(punct[$urandom_range(0, 5)], 1'b0);
      end
    end

    in_chan.valid <= 1'b0;
    do @(posedge clk); while (tokens_due != 0);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("summary: %0d bytes and end marks scanned, %0d tokens compared",
             items_taken, tokens_checked);
    $display("summary: %0d of 15 token kinds produced, one full drain on the way",
             $countones(kinds_hit));
    if (fault_count == 0 && tokens_due == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/tds_pkg.sv
hw/rtl/tds_if.sv
hw/rtl/tds_step.sv
hw/rtl/tds_outq.sv
hw/rtl/table_driven_token_scanner.sv
dv/tds_scan_checker.sv
dv/tb_top.sv
